@@ rtl/prf_pkg.sv @@
// Shared types, sizes and register codes for the page replacement block.
// Used by every module under rtl; depends on nothing else.
package prf_pkg;

  localparam int FRAMES      = 8;
  localparam int PAGE_BITS   = 16;
  localparam int STAMP_BITS  = 32;
  localparam int FAULT_BITS  = 32;

  localparam int FRAME_IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FRAME_CNT_W = $clog2(FRAMES + 1);

  localparam int SLOT_W      = 3;
  localparam int FRAMES_CFG_W = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  localparam logic [FRAMES_CFG_W-1:0] FRAMES_CFG_RESET = 4'd8;

  // Register index, taken from the word address.
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_FRAMES = 1'b1;

  // Replacement policies.
  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  typedef struct packed {
    logic [PAGE_BITS-1:0]  page;
    logic [STAMP_BITS-1:0] load;
    logic [STAMP_BITS-1:0] last;
  } frame_entry_t;

  typedef struct packed {
    logic                   re;
    logic [FRAME_IDX_W-1:0] raddr;
    logic                   we;
    logic [FRAME_IDX_W-1:0] waddr;
    frame_entry_t           wdata;
  } ram_req_t;

  typedef struct packed {
    logic                    mode;
    logic [FRAMES_CFG_W-1:0] frames;
  } cfg_t;

endpackage

@@ rtl/page_replacement_fifo_lru.sv @@
// Page replacement engine with FIFO or LRU victim choice. Each item carries one
// page reference and yields exactly one result item. The frame table (page,
// load stamp, last-use stamp) lives in a synchronous memory with one read and
// one write port, so the table is scanned one frame per cycle: once accepted,
// an item goes through a scan of the n active frames and then a commit step
// that loads its result item, and the next item is taken only after that
// commit. A result item still held off by the receiver when the next one is
// ready to commit holds that commit back until it is taken. in_stall is high
// while an item is being worked on; a finished result item sits in an output
// register, so the next item is taken while it waits. Valid marks are kept
// in flip-flops that reset clears at once, so there is no clearing pass after
// reset, and a reference with start_run set clears them, together with the
// step and fault counters, before it is handled.
// Configuration is written through the cfg_ port at byte address 0 (policy,
// 0 FIFO, 1 LRU) and 4 (active frame count) and is to be changed only while
// the block is idle.

module page_replacement_fifo_lru
  import prf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PAGE_BITS-1:0]  in_page_number,
  input  logic                  in_start_run,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_fault,
  output logic [SLOT_W-1:0]     out_slot_used,
  output logic                  out_evicted_valid,
  output logic [PAGE_BITS-1:0]  out_evicted_page,
  output logic [FAULT_BITS-1:0] out_fault_total
);

  cfg_t         cfg;
  ram_req_t     ram_req;
  frame_entry_t ram_rdata;

  // Policy and frame count registers.
  prf_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // The frame table itself.
  prf_frame_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // Sequencer: scan, choose the frame, write back unless a FIFO hit, and hold the result item.
  prf_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page_number    (in_page_number),
    .in_start_run      (in_start_run),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_fault         (out_fault),
    .out_slot_used     (out_slot_used),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total),
    .ram_req           (ram_req),
    .ram_rdata         (ram_rdata)
  );

endmodule

@@ rtl/prf_frame_ram.sv @@
// Frame table memory: one write port, one read port, registered read data.
// Depends on prf_pkg for the entry layout and the request struct.
module prf_frame_ram
  import prf_pkg::*;
(
  input  logic         clk,
  input  ram_req_t     req,
  output frame_entry_t rdata
);

  frame_entry_t mem [FRAMES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ rtl/prf_cfg_regs.sv @@
// Configuration registers behind the APB-style port: policy and frame count.
// Depends on prf_pkg for the register codes and the configuration struct.
module prf_cfg_regs
  import prf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  logic                    mode_r;
  logic                    mode_nxt;
  logic [FRAMES_CFG_W-1:0] frames_r;
  logic [FRAMES_CFG_W-1:0] frames_nxt;
  logic                    wr_en;
  logic                    reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[2];

  always_comb begin
    mode_nxt   = mode_r;
    frames_nxt = frames_r;
    cfg_prdata = '0;
    unique case (reg_idx)
      REG_MODE: begin
        cfg_prdata = CFG_DATA_W'(mode_r);
        if (wr_en) mode_nxt = cfg_pwdata[0];
      end
      REG_FRAMES: begin
        cfg_prdata = CFG_DATA_W'(frames_r);
        if (wr_en) frames_nxt = cfg_pwdata[FRAMES_CFG_W-1:0];
      end
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_FIFO;
      frames_r <= FRAMES_CFG_RESET;
    end else begin
      mode_r   <= mode_nxt;
      frames_r <= frames_nxt;
    end
  end

  assign cfg.mode   = mode_r;
  assign cfg.frames = frames_r;

endmodule

@@ rtl/prf_engine.sv @@
// Reference sequencer: scans the frame memory, picks hit, empty or victim
// frame, writes back (not on a FIFO hit) and holds the result item. Depends on prf_pkg.
module prf_engine
  import prf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PAGE_BITS-1:0]  in_page_number,
  input  logic                  in_start_run,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_fault,
  output logic [SLOT_W-1:0]     out_slot_used,
  output logic                  out_evicted_valid,
  output logic [PAGE_BITS-1:0]  out_evicted_page,
  output logic [FAULT_BITS-1:0] out_fault_total,
  output ram_req_t              ram_req,
  input  frame_entry_t          ram_rdata
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE} state_t;

  state_t                 state_r, state_nxt;
  logic [PAGE_BITS-1:0]   page_r, page_nxt;
  logic [STAMP_BITS-1:0]  stamp_r, stamp_nxt;
  logic [STAMP_BITS-1:0]  step_cnt_r, step_cnt_nxt;
  logic [FAULT_BITS-1:0]  fault_cnt_r, fault_cnt_nxt;
  logic [FRAMES-1:0]      valid_r, valid_nxt;
  logic [FRAME_CNT_W-1:0] n_r, n_nxt;
  logic [FRAME_CNT_W-1:0] iss_cnt_r, iss_cnt_nxt;
  logic                   pend_r, pend_nxt;
  logic [FRAME_IDX_W-1:0] proc_idx_r, proc_idx_nxt;
  logic                   hit_r, hit_nxt;
  logic [FRAME_IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [STAMP_BITS-1:0]  hit_load_r, hit_load_nxt;
  logic                   empty_r, empty_nxt;
  logic [FRAME_IDX_W-1:0] empty_idx_r, empty_idx_nxt;
  logic [FRAME_IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [STAMP_BITS-1:0]  best_age_r, best_age_nxt;
  logic [PAGE_BITS-1:0]   best_page_r, best_page_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_fault_r, out_fault_nxt;
  logic [SLOT_W-1:0]      out_slot_r, out_slot_nxt;
  logic                   out_ev_valid_r, out_ev_valid_nxt;
  logic [PAGE_BITS-1:0]   out_ev_page_r, out_ev_page_nxt;
  logic [FAULT_BITS-1:0]  out_total_r, out_total_nxt;

  logic                   in_acc;
  logic [FRAME_CNT_W-1:0] act_n;
  logic [STAMP_BITS-1:0]  stamp_base;
  logic [STAMP_BITS-1:0]  age;
  logic [FRAME_IDX_W-1:0] slot;
  logic                   is_miss;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // A frame count of zero behaves as one, anything above the table as the table.
  always_comb begin
    if (cfg.frames == '0) begin
      act_n = FRAME_CNT_W'(1);
    end else if (32'(cfg.frames) > 32'(FRAMES)) begin
      act_n = FRAME_CNT_W'(FRAMES);
    end else begin
      act_n = FRAME_CNT_W'(cfg.frames);
    end
  end

  assign age     = (cfg.mode == MODE_LRU) ? ram_rdata.last : ram_rdata.load;
  assign is_miss = !hit_r;
  assign slot    = hit_r ? hit_idx_r : (empty_r ? empty_idx_r : best_idx_r);

  always_comb begin
    state_nxt        = state_r;
    page_nxt         = page_r;
    stamp_nxt        = stamp_r;
    step_cnt_nxt     = step_cnt_r;
    fault_cnt_nxt    = fault_cnt_r;
    valid_nxt        = valid_r;
    n_nxt            = n_r;
    iss_cnt_nxt      = iss_cnt_r;
    pend_nxt         = 1'b0;
    proc_idx_nxt     = proc_idx_r;
    hit_nxt          = hit_r;
    hit_idx_nxt      = hit_idx_r;
    hit_load_nxt     = hit_load_r;
    empty_nxt        = empty_r;
    empty_idx_nxt    = empty_idx_r;
    best_idx_nxt     = best_idx_r;
    best_age_nxt     = best_age_r;
    best_page_nxt    = best_page_r;
    out_valid_nxt    = out_valid_r;
    out_fault_nxt    = out_fault_r;
    out_slot_nxt     = out_slot_r;
    out_ev_valid_nxt = out_ev_valid_r;
    out_ev_page_nxt  = out_ev_page_r;
    out_total_nxt    = out_total_r;
    stamp_base       = step_cnt_r;
    ram_req          = '0;
    ram_req.raddr    = iss_cnt_r[FRAME_IDX_W-1:0];
    ram_req.waddr    = slot;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          page_nxt    = in_page_number;
          n_nxt       = act_n;
          iss_cnt_nxt = '0;
          hit_nxt     = 1'b0;
          empty_nxt   = 1'b0;
          if (in_start_run) begin
            valid_nxt     = '0;
            fault_cnt_nxt = '0;
            stamp_base    = '0;
          end
          stamp_nxt    = stamp_base;
          step_cnt_nxt = (stamp_base == '1) ? stamp_base : stamp_base + STAMP_BITS'(1);
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue one read per cycle; the entry read last cycle is examined now.
        if (iss_cnt_r < n_r) begin
          ram_req.re   = 1'b1;
          pend_nxt     = 1'b1;
          proc_idx_nxt = iss_cnt_r[FRAME_IDX_W-1:0];
          iss_cnt_nxt  = iss_cnt_r + FRAME_CNT_W'(1);
        end else begin
          state_nxt = S_WRITE;
        end
        if (pend_r) begin
          if (valid_r[proc_idx_r] && (ram_rdata.page == page_r) && !hit_r) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = proc_idx_r;
            hit_load_nxt = ram_rdata.load;
          end
          if (!valid_r[proc_idx_r] && !empty_r) begin
            empty_nxt     = 1'b1;
            empty_idx_nxt = proc_idx_r;
          end
          // Strict compare keeps the lowest index among equal stamps.
          if ((proc_idx_r == '0) || (age < best_age_r)) begin
            best_idx_nxt  = proc_idx_r;
            best_age_nxt  = age;
            best_page_nxt = ram_rdata.page;
          end
        end
      end
      S_WRITE: begin
        if (!out_valid_r || !out_stall) begin
          ram_req.wdata.page = page_r;
          ram_req.wdata.last = stamp_r;
          if (hit_r) begin
            ram_req.we         = (cfg.mode == MODE_LRU);
            ram_req.wdata.load = hit_load_r;
          end else begin
            ram_req.we         = 1'b1;
            ram_req.wdata.load = stamp_r;
            valid_nxt[slot]    = 1'b1;
            if (fault_cnt_r != '1) fault_cnt_nxt = fault_cnt_r + FAULT_BITS'(1);
          end
          out_valid_nxt    = 1'b1;
          out_fault_nxt    = is_miss;
          out_slot_nxt     = SLOT_W'(slot);
          out_ev_valid_nxt = is_miss && !empty_r;
          out_ev_page_nxt  = (is_miss && !empty_r) ? best_page_r : '0;
          out_total_nxt    = fault_cnt_nxt;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_cnt_r  <= '0;
      fault_cnt_r <= '0;
      valid_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_cnt_r  <= step_cnt_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      valid_r     <= valid_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    page_r         <= page_nxt;
    stamp_r        <= stamp_nxt;
    n_r            <= n_nxt;
    iss_cnt_r      <= iss_cnt_nxt;
    proc_idx_r     <= proc_idx_nxt;
    hit_r          <= hit_nxt;
    hit_idx_r      <= hit_idx_nxt;
    hit_load_r     <= hit_load_nxt;
    empty_r        <= empty_nxt;
    empty_idx_r    <= empty_idx_nxt;
    best_idx_r     <= best_idx_nxt;
    best_age_r     <= best_age_nxt;
    best_page_r    <= best_page_nxt;
    out_fault_r    <= out_fault_nxt;
    out_slot_r     <= out_slot_nxt;
    out_ev_valid_r <= out_ev_valid_nxt;
    out_ev_page_r  <= out_ev_page_nxt;
    out_total_r    <= out_total_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_fault         = out_fault_r;
  assign out_slot_used     = out_slot_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_total   = out_total_r;

  a_write_only_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> (state_r == S_WRITE))
    else $error("frame memory written outside the commit step");

  a_eviction_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_valid_r) |-> out_fault_r)
    else $error("eviction reported on a hit");

  a_valid_stable_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> $stable(valid_r))
    else $error("valid bits changed during the scan");

  a_faults_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !(in_acc && in_start_run)) |=> (fault_cnt_r >= $past(fault_cnt_r)))
    else $error("fault count fell without a run start");

endmodule
